// ===== rtl/core/aekd_pkg.sv =====
// Shared types and constants for the asymmetric per-key debouncer.
// No dependencies; used by aekd_key_lane, aekd_row_store and the top level.
package aekd_pkg;

	// Field widths of the stream items
	localparam int ROW_W     = 3;
	localparam int ROW_BITS  = 16;
	localparam int ELAPSED_W = 8;
	localparam int TIMER_W   = 7;

	// Default matrix size
	localparam int ROWS_DEF = 8;
	localparam int COLS_DEF = 16;

	// Timer codes and register reset
	localparam logic [TIMER_W-1:0] TIMER_IDLE     = '0;
	localparam logic [TIMER_W-1:0] TIMER_MIN_LOAD = TIMER_W'(1);
	localparam logic [TIMER_W-1:0] DEBOUNCE_RESET = TIMER_W'(5);

	// Per-key state: direction 1 guards a press, 0 guards a release
	typedef struct packed {
		logic               dir;
		logic [TIMER_W-1:0] timer;
	} key_state_t;

endpackage

// ===== rtl/core/aekd_key_lane.sv =====
// One key's countdown and change check, pure combinational logic.
// Depends on aekd_pkg for key_state_t and timer constants.
module aekd_key_lane (
	input  aekd_pkg::key_state_t                cur,
	input  logic                                cooked,
	input  logic                                raw,
	input  logic [aekd_pkg::ELAPSED_W-1:0]      elapsed,
	input  logic [aekd_pkg::TIMER_W-1:0]        load,
	output aekd_pkg::key_state_t                nxt,
	output logic                                cooked_nxt
);

	logic                         running;
	logic                         expire;
	logic [aekd_pkg::TIMER_W-1:0] timer_cd;
	logic                         cooked_cd;

	// Count the running timer down; an expired release timer copies raw
	always_comb begin
		running = (cur.timer != aekd_pkg::TIMER_IDLE);
		expire  = running && ({1'b0, cur.timer} <= elapsed);
		if (!running || expire) begin
			timer_cd = aekd_pkg::TIMER_IDLE;
		end else begin
			timer_cd = cur.timer - elapsed[aekd_pkg::TIMER_W-1:0];
		end
		cooked_cd = (expire && !cur.dir) ? raw : cooked;
	end

	// Arm on a change with an idle timer; press applies at once,
	// a release timer drops when raw comes back to the cooked value
	always_comb begin
		nxt.dir    = cur.dir;
		nxt.timer  = timer_cd;
		cooked_nxt = cooked_cd;
		if (raw != cooked_cd) begin
			if (timer_cd == aekd_pkg::TIMER_IDLE) begin
				nxt.dir    = raw;
				nxt.timer  = load;
				cooked_nxt = cooked_cd | raw;
			end
		end else if ((timer_cd != aekd_pkg::TIMER_IDLE) && !cur.dir) begin
			nxt.timer = aekd_pkg::TIMER_IDLE;
		end
	end

endmodule

// ===== rtl/core/aekd_row_store.sv =====
// Per-row state registers: key timers, directions and cooked bits.
// Depends on aekd_pkg; one read and one write address (the same row).
module aekd_row_store #(
	parameter int ROWS   = aekd_pkg::ROWS_DEF,
	parameter int NCOLS  = aekd_pkg::COLS_DEF,
	parameter int RIDX_W = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [RIDX_W-1:0]                   idx,
	output aekd_pkg::key_state_t [NCOLS-1:0]    rd_keys,
	output logic [NCOLS-1:0]                    rd_cooked,
	input  logic                                wr_en,
	input  aekd_pkg::key_state_t [NCOLS-1:0]    wr_keys,
	input  logic [NCOLS-1:0]                    wr_cooked
);

	aekd_pkg::key_state_t [NCOLS-1:0] keys_q   [ROWS];
	logic [NCOLS-1:0]                 cooked_q [ROWS];

	// Read the addressed row
	assign rd_keys   = keys_q[idx];
	assign rd_cooked = cooked_q[idx];

	// Clear all rows on reset, write back the processed row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				keys_q[r]   <= '0;
				cooked_q[r] <= '0;
			end
		end else if (wr_en) begin
			keys_q[idx]   <= wr_keys;
			cooked_q[idx] <= wr_cooked;
		end
	end

endmodule

// ===== rtl/core/asym_eager_defer_key_debounce.sv =====
// Top level of the asymmetric per-key debouncer (eager press, deferred release).
// Depends on aekd_pkg, aekd_row_store and aekd_key_lane.
//
// Channel  Dir  Signals                      Contents (low bit up)
// s_*      in   tvalid tready tdata tuser    tdata: raw_bits, elapsed_ticks; tuser: row_index
// m_*      out  tvalid tready tdata tuser    tdata: cooked_bits; tuser: row_changed
// cfg_*    in   we wdata                     debounce_ticks
//
// One row per cycle sustained while the output is not stalled. The input register
// feeds the key lanes, which read and write back the row state in the same cycle
// and load the output register. Reset clears all key timers, directions and cooked
// rows at once and sets debounce_ticks to 5. A stalled output holds its beat;
// the input register still takes a new beat as soon as its contents move on.
module asym_eager_defer_key_debounce #(
	parameter int ROWS = aekd_pkg::ROWS_DEF,
	parameter int COLS = aekd_pkg::COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] raw_bits, [23:16] elapsed_ticks
	input  logic [2:0]  s_tuser,   // [2:0] row_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] cooked_bits
	output logic [0:0]  m_tuser,   // [0] row_changed
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata  // [6:0] debounce_ticks
);

	localparam int NCOLS  = (COLS < aekd_pkg::ROW_BITS) ? COLS : aekd_pkg::ROW_BITS;
	localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [aekd_pkg::TIMER_W-1:0]   debounce_q;

	logic                           valid_s1;
	logic [aekd_pkg::ROW_W-1:0]     row_s1;
	logic [aekd_pkg::ROW_BITS-1:0]  raw_s1;
	logic [aekd_pkg::ELAPSED_W-1:0] elapsed_s1;

	logic                           valid_s2;
	logic [aekd_pkg::ROW_BITS-1:0]  cooked_s2;
	logic                           changed_s2;

	logic                             advance;
	logic                             row_ok;
	logic [aekd_pkg::TIMER_W-1:0]     load;
	aekd_pkg::key_state_t [NCOLS-1:0] keys_cur;
	aekd_pkg::key_state_t [NCOLS-1:0] keys_nxt;
	logic [NCOLS-1:0]                 cooked_cur;
	logic [NCOLS-1:0]                 cooked_nxt;
	logic [aekd_pkg::ROW_BITS-1:0]    cooked_out;
	logic                             changed_out;

	// Hold the lock-out time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= aekd_pkg::DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	// Advance when the output register is free or drains this cycle
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			row_s1     <= s_tuser;
			raw_s1     <= s_tdata[15:0];
			elapsed_s1 <= s_tdata[23:16];
		end
	end

	assign row_ok = (int'(row_s1) < ROWS);
	assign load   = (debounce_q == aekd_pkg::TIMER_IDLE) ? aekd_pkg::TIMER_MIN_LOAD
	                                                       : debounce_q;

	aekd_row_store #(
		.ROWS   (ROWS),
		.NCOLS  (NCOLS),
		.RIDX_W (RIDX_W)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.idx       (RIDX_W'(row_s1)),
		.rd_keys   (keys_cur),
		.rd_cooked (cooked_cur),
		.wr_en     (advance && row_ok),
		.wr_keys   (keys_nxt),
		.wr_cooked (cooked_nxt)
	);

	// One lane per existing column
	for (genvar c = 0; c < NCOLS; c++) begin : g_lane
		aekd_key_lane u_lane (
			.cur        (keys_cur[c]),
			.cooked     (cooked_cur[c]),
			.raw        (raw_s1[c]),
			.elapsed    (elapsed_s1),
			.load       (load),
			.nxt        (keys_nxt[c]),
			.cooked_nxt (cooked_nxt[c])
		);
	end

	// Zero the result for a row beyond the matrix
	assign cooked_out  = row_ok ? aekd_pkg::ROW_BITS'(cooked_nxt) : '0;
	assign changed_out = row_ok && (cooked_nxt != cooked_cur);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cooked_s2  <= cooked_out;
			changed_s2 <= changed_out;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = cooked_s2;
	assign m_tuser[0] = changed_s2;

endmodule

// ===== rtl/core/aekd_checker.sv =====
// Port-level checks for the debouncer top level, attached by bind.
// Depends only on the top level's ports.
module aekd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output beat changed while stalled");

	// A draining output never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// An accepted beat passes the input and output registers and then shows a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> ##1 m_tvalid)
		else $error("no result after accepted beat");

endmodule

bind asym_eager_defer_key_debounce aekd_checker u_aekd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== sim/testbench.sv =====
// Self-checking bench for the asymmetric per-key debouncer (eager press, deferred release).
// Depends on aekd_pkg and asym_eager_defer_key_debounce; holds a per-key model of the matrix
// and checks every output beat against it while both stream sides idle and stall at random.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MATRIX_ROWS = aekd_pkg::ROWS_DEF;
	localparam int KEY_COLS    = aekd_pkg::COLS_DEF;

	localparam int ROW_W     = aekd_pkg::ROW_W;
	localparam int ROW_BITS  = aekd_pkg::ROW_BITS;
	localparam int ELAPSED_W = aekd_pkg::ELAPSED_W;
	localparam int TIMER_W   = aekd_pkg::TIMER_W;

	localparam logic [TIMER_W-1:0] TIMER_IDLE     = aekd_pkg::TIMER_IDLE;
	localparam logic [TIMER_W-1:0] TIMER_MIN_LOAD = aekd_pkg::TIMER_MIN_LOAD;
	localparam logic [TIMER_W-1:0] DEBOUNCE_RESET = aekd_pkg::DEBOUNCE_RESET;

	typedef struct {
		logic [ROW_BITS-1:0] cooked;
		logic                changed;
	} row_result_t;

	// Track the debounced matrix and the cooked rows still owed by the block
	class cooked_row_tracker;
		logic [TIMER_W-1:0]  lock_timer [MATRIX_ROWS][KEY_COLS];
		logic                guards_press [MATRIX_ROWS][KEY_COLS];
		logic [ROW_BITS-1:0] cooked_now [MATRIX_ROWS];
		logic [TIMER_W-1:0]  lockout;
		row_result_t         cooked_due [$];
		int                  faults;

		function new();
			for (int r = 0; r < MATRIX_ROWS; r++) begin
				cooked_now[r] = '0;
				for (int c = 0; c < KEY_COLS; c++) begin
					lock_timer[r][c]   = TIMER_IDLE;
					guards_press[r][c] = 1'b0;
				end
			end
			lockout = DEBOUNCE_RESET;
			faults  = 0;
		endfunction

		function void set_lockout(logic [TIMER_W-1:0] ticks);
			lockout = ticks;
		endfunction

		function int pending();
			return cooked_due.size();
		endfunction

		// Run the countdown and check passes over one scanned row
		function void note_scan(logic [ROW_W-1:0] row, logic [ROW_BITS-1:0] raw,
				logic [ELAPSED_W-1:0] elapsed);
			logic [TIMER_W-1:0]  load;
			logic [ROW_BITS-1:0] prior;
			logic [ROW_BITS-1:0] cooked;
			logic [ROW_BITS-1:0] delta;
			row_result_t         res;
			load   = (lockout == TIMER_IDLE) ? TIMER_MIN_LOAD : lockout;
			prior  = cooked_now[row];
			cooked = prior;
			// count down running timers; an expiring release guard takes the raw bit
			for (int c = 0; c < KEY_COLS; c++) begin
				if (lock_timer[row][c] != TIMER_IDLE) begin
					if (ELAPSED_W'(lock_timer[row][c]) <= elapsed) begin
						lock_timer[row][c] = TIMER_IDLE;
						if (!guards_press[row][c])
							cooked[c] = raw[c];
					end else begin
						lock_timer[row][c] = lock_timer[row][c] - TIMER_W'(elapsed);
					end
				end
			end
			// arm idle keys that moved; apply presses now, cancel settled release guards
			delta = raw ^ cooked;
			for (int c = 0; c < KEY_COLS; c++) begin
				if (delta[c]) begin
					if (lock_timer[row][c] == TIMER_IDLE) begin
						guards_press[row][c] = raw[c];
						lock_timer[row][c]   = load;
						if (raw[c])
							cooked[c] = 1'b1;
					end
				end else if (lock_timer[row][c] != TIMER_IDLE && !guards_press[row][c]) begin
					lock_timer[row][c] = TIMER_IDLE;
				end
			end
			cooked_now[row] = cooked;
			res.cooked  = cooked;
			res.changed = (cooked != prior);
			cooked_due.push_back(res);
		endfunction

		function void complain(string what);
			faults++;
			if (faults <= 10)
				$display("%0t mismatch: %s", $time, what);
		endfunction

		// Compare one output beat with the oldest owed row
		function void check_row(logic [ROW_BITS-1:0] cooked, logic changed);
			row_result_t want;
			if (cooked_due.size() == 0) begin
				complain($sformatf("unexpected beat cooked=%h changed=%b", cooked, changed));
				return;
			end
			want = cooked_due.pop_front();
			if (cooked !== want.cooked)
				complain($sformatf("cooked_bits expected %h actual %h", want.cooked, cooked));
			if (changed !== want.changed)
				complain($sformatf("row_changed expected %b actual %b", want.changed, changed));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [15:0] raw_bits, [23:16] elapsed_ticks
	logic [2:0]  s_tuser;   // [2:0] row_index
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] cooked_bits
	logic [0:0]  m_tuser;   // [0] row_changed
	logic        cfg_we;
	logic [6:0]  cfg_wdata; // [6:0] debounce_ticks

	cooked_row_tracker   sb;
	int                  cycle_count = 0;
	bit                  tx_steady   = 0;
	bit                  rx_steady   = 0;
	int                  hold_off    = 0;
	int                  lockout_now = int'(DEBOUNCE_RESET);
	logic [ROW_BITS-1:0] raw_now [MATRIX_ROWS];

	asym_eager_defer_key_debounce u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Abort a hung run
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Drive the output ready: random stalls, steady stretches and forced hold-offs
	initial begin : ready_driver
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready = 1'b0;
				hold_off--;
			end else if (rx_steady) begin
				m_tready = 1'b1;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready   = 1'b1;
				stall_left = ($urandom_range(0, 3) == 0) ? draw_gap() : 0;
			end
		end
	end

	// Check every output beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_row(m_tdata, m_tuser[0]);
	end

	// Offer one scan beat and hold it until taken; returns at the following falling edge
	task automatic send_scan(input logic [ROW_W-1:0] row, input logic [ROW_BITS-1:0] raw,
			input logic [ELAPSED_W-1:0] elapsed);
		int gap;
		gap = tx_steady ? 0 : draw_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {elapsed, raw};
		s_tuser  = row;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_scan(row, raw, elapsed);
		@(negedge clk);
	endtask

	task automatic write_lockout(input logic [6:0] ticks);
		cfg_we    = 1'b1;
		cfg_wdata = ticks;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_lockout(ticks);
		lockout_now = int'(ticks);
	endtask

	// Drop valid, wait for every owed row, then let the pipeline settle
	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Random scans: mostly small bounces on a per-row raw image, some noise
	task automatic scan_matrix(input int count);
		logic [ROW_W-1:0]     row;
		logic [ELAPSED_W-1:0] elapsed;
		int                   pick;
		int                   top;
		for (int n = 0; n < count; n++) begin
			row  = ROW_W'($urandom_range(0, MATRIX_ROWS - 1));
			pick = $urandom_range(0, 99);
			if (pick < 55)
				raw_now[row] ^= ROW_BITS'(1) << $urandom_range(0, ROW_BITS - 1);
			else if (pick < 70)
				raw_now[row] ^= ROW_BITS'($urandom() & $urandom() & $urandom());
			else if (pick < 85)
				raw_now[row] = raw_now[row];
			else if (pick < 95)
				raw_now[row] = ROW_BITS'($urandom());
			else
				raw_now[row] = $urandom_range(0, 1) ? '1 : '0;
			pick = $urandom_range(0, 99);
			top  = (lockout_now + 2 > 255) ? 255 : lockout_now + 2;
			if (pick < 55)
				elapsed = ELAPSED_W'($urandom_range(0, 3));
			else if (pick < 85)
				elapsed = ELAPSED_W'($urandom_range(0, top));
			else if (pick < 95)
				elapsed = ELAPSED_W'($urandom_range(0, 255));
			else
				elapsed = '1;
			send_scan(row, raw_now[row], elapsed);
		end
		s_tvalid = 1'b0;
	endtask

	initial begin : main
		sb        = new();
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		for (int r = 0; r < MATRIX_ROWS; r++)
			raw_now[r] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: eager press, deferred release, bounce cancel, edge columns, big elapsed
		send_scan(3'd0, 16'hFFFF, 8'd0);
		send_scan(3'd0, 16'h0000, 8'd0);
		send_scan(3'd0, 16'h0000, 8'd4);
		send_scan(3'd0, 16'h0000, 8'd1);
		send_scan(3'd0, 16'hFFFF, 8'd2);
		send_scan(3'd0, 16'h0000, 8'd0);
		send_scan(3'd0, 16'h0000, 8'd255);
		send_scan(3'd7, 16'h8001, 8'd255);
		send_scan(3'd7, 16'h8001, 8'd255);
		send_scan(3'd7, 16'h0000, 8'd5);
		send_scan(3'd7, 16'h0000, 8'd0);
		send_scan(3'd3, 16'hA5A5, 8'd0);
		send_scan(3'd3, 16'h5A5A, 8'd200);
		send_scan(3'd3, 16'h5A5A, 8'd255);
		send_scan(3'd3, 16'h5A5A, 8'd128);
		send_scan(3'd5, 16'h0000, 8'd0);
		send_scan(3'd6, 16'h0001, 8'd7);
		send_scan(3'd6, 16'h0000, 8'd0);
		send_scan(3'd6, 16'h0001, 8'd3);
		drain();
		for (int r = 0; r < MATRIX_ROWS; r++)
			raw_now[r] = sb.cooked_now[r];
		scan_matrix(220);
		drain();

		// Shortest lockout, no idling on either side
		write_lockout(7'd1);
		tx_steady = 1;
		rx_steady = 1;
		scan_matrix(180);
		drain();
		tx_steady = 0;
		rx_steady = 0;

		// Longest lockout; hold the output off so the input backs up
		write_lockout(7'd127);
		hold_off = 300;
		scan_matrix(160);
		drain();

		// Zero lockout acts as one
		write_lockout(7'd0);
		send_scan(3'd2, 16'h00FF, 8'd0);
		send_scan(3'd2, 16'h0000, 8'd0);
		send_scan(3'd2, 16'h0000, 8'd1);
		send_scan(3'd2, 16'h0000, 8'd1);
		scan_matrix(150);
		drain();

		write_lockout(7'($urandom_range(2, 20)));
		hold_off = 120;
		scan_matrix(250);
		drain();

		repeat (10) @(posedge clk);
		if (sb.faults == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/aekd_pkg.sv
rtl/core/aekd_key_lane.sv
rtl/core/aekd_row_store.sv
rtl/core/asym_eager_defer_key_debounce.sv
rtl/core/aekd_checker.sv
sim/testbench.sv
